[rtl/feedback_delay_echo_macros.svh]
// feedback_delay_echo_macros.svh: assertion macros for the echo block checkers.
// Used by files that assert; no other dependencies.
`ifndef FEEDBACK_DELAY_ECHO_MACROS_SVH
`define FEEDBACK_DELAY_ECHO_MACROS_SVH

// Same-cycle implication.
`define FDE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define FDE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/fde_pkg.sv]
// fde_pkg: widths, register indexes and constants of the feedback delay echo.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package fde_pkg;

   localparam int SAMPLE_W            = 16;
   localparam int DELAY_W             = 17;
   localparam int GAIN_W              = 16;
   localparam int LEVEL_W             = 8;
   localparam int CSR_INDEX_W         = 2;
   localparam int CSR_DATA_W          = 17;
   localparam int STORE_DEPTH_DEFAULT = 65536;

   // x/255 as (x * RECIP) >> SHIFT, exact for x below 2^24
   localparam int              DIV255_SHIFT = 31;
   localparam logic [23:0]     DIV255_RECIP = 24'd8421505;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
   localparam logic signed [SAMPLE_W-1:0] FULL_SCALE = 16'sd32767;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ENABLE        = 2'd0,
      REG_DELAY_LENGTH  = 2'd1,
      REG_FEEDBACK_GAIN = 2'd2,
      REG_WET_LEVEL     = 2'd3
   } csr_index_type;

endpackage

`default_nettype wire

[rtl/fde_ram.sv]
// fde_ram: generic single-clock RAM, one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module fde_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/feedback_delay_echo.sv]
// feedback_delay_echo: stereo feedback echo over a circular mono store in RAM.
// Depends on fde_pkg and fde_ram.
//
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/stall   | req_left_in, req_right_in (s16)
//  rsp     | out       | rsp_valid/stall   | rsp_left_out, rsp_right_out (s16)
//  csr     | in        | csr_write         | csr_index (2), csr_data (17)
//
// One word per clock while rsp is not stalled; a word taken passes the stages in
// order (RAM read into B, mix into C, divide-by-255 into the output).
// The store feedback loop closes within stage B: multiply, add, clamp, write.
// Reset is synchronous; no clearing pass: entries not yet written read as zero,
// tracked by the write position and a wrapped flag.
// A stall on rsp backs up through the stages; req_stall rises only then.
`default_nettype none

module feedback_delay_echo
   import fde_pkg::*;
#(
   parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // input words
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic signed [SAMPLE_W-1:0] req_left_in,
   input  wire logic signed [SAMPLE_W-1:0] req_right_in,
   // result words
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0]      rsp_left_out,
   output logic signed [SAMPLE_W-1:0]      rsp_right_out,
   // configuration writes
   input  wire logic                       csr_write,
   input  wire logic [CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]      csr_data
);

   localparam int AW = $clog2(STORE_DEPTH);
   // wide enough for the delay register and for STORE_DEPTH itself
   localparam int DW = (AW + 1 > DELAY_W) ? AW + 1 : DELAY_W;

   // ---------------------------------------------------------------- config
   logic                enable_ff,       enable_in;
   logic [DELAY_W-1:0]  delay_length_ff, delay_length_in;
   logic [GAIN_W-1:0]   feedback_gain_ff, feedback_gain_in;
   logic [LEVEL_W-1:0]  wet_level_ff,    wet_level_in;

   always_comb begin
      enable_in        = enable_ff;
      delay_length_in  = delay_length_ff;
      feedback_gain_in = feedback_gain_ff;
      wet_level_in     = wet_level_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            REG_ENABLE:        enable_in        = csr_data[0];
            REG_DELAY_LENGTH:  delay_length_in  = csr_data[DELAY_W-1:0];
            REG_FEEDBACK_GAIN: feedback_gain_in = csr_data[GAIN_W-1:0];
            REG_WET_LEVEL:     wet_level_in     = csr_data[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff        <= 1'b0;
         delay_length_ff  <= DELAY_W'(1);
         feedback_gain_ff <= '0;
         wet_level_ff     <= '0;
      end else begin
         enable_ff        <= enable_in;
         delay_length_ff  <= delay_length_in;
         feedback_gain_ff <= feedback_gain_in;
         wet_level_ff     <= wet_level_in;
      end
   end

   // ---------------------------------------------------------- flow control
   logic b_valid_ff, b_valid_in;
   logic c_valid_ff, c_valid_in;
   logic o_valid_ff, o_valid_in;
   logic o_free, c_free, b_free;
   logic req_accept;

   assign o_free     = !o_valid_ff || !rsp_stall;
   assign c_free     = !c_valid_ff || o_free;
   assign b_free     = !b_valid_ff || c_free;
   assign req_stall  = !b_free;
   assign req_accept = req_valid && b_free;

   assign b_valid_in = b_free ? req_valid  : b_valid_ff;
   assign c_valid_in = c_free ? b_valid_ff : c_valid_ff;
   assign o_valid_in = o_free ? c_valid_ff : o_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   // ------------------------------------------------- read address (stage A)
   logic [AW-1:0] wp_ff, wp_in;
   logic          wrapped_ff, wrapped_in;
   logic [DW-1:0] delay_ext, delay_eff, wp_ext, rd_full;
   logic [AW-1:0] rd_addr;
   logic          rd_written;

   always_comb begin
      delay_ext = DW'(delay_length_ff);
      if (delay_ext == '0) begin
         delay_eff = DW'(1);
      end else if (delay_ext > DW'(STORE_DEPTH)) begin
         delay_eff = DW'(STORE_DEPTH);      // reads the entry about to be overwritten
      end else begin
         delay_eff = delay_ext;
      end
      wp_ext = DW'(wp_ff);
      if (wp_ext >= delay_eff) begin
         rd_full = wp_ext - delay_eff;
      end else begin
         rd_full = wp_ext + DW'(STORE_DEPTH) - delay_eff;
      end
   end

   assign rd_addr    = rd_full[AW-1:0];
   // positions 0..wp-1 are written once, everything once wrapped
   assign rd_written = wrapped_ff || (rd_addr < wp_ff);

   always_comb begin
      wp_in      = wp_ff;
      wrapped_in = wrapped_ff;
      if (req_accept && enable_ff) begin
         if (wp_ff == AW'(STORE_DEPTH - 1)) begin
            wp_in      = '0;
            wrapped_in = 1'b1;
         end else begin
            wp_in = wp_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         wp_ff      <= wp_in;
         wrapped_ff <= wrapped_in;
      end
   end

   // ------------------------------------------------ stage B registers
   logic signed [SAMPLE_W-1:0] b_left_ff,  b_left_in;
   logic signed [SAMPLE_W-1:0] b_right_ff, b_right_in;
   logic [AW-1:0]              b_wp_ff,    b_wp_in;
   logic                       b_ok_ff,    b_ok_in;
   logic                       b_fwd_ff,   b_fwd_in;
   logic signed [SAMPLE_W-1:0] b_fwd_data_ff, b_fwd_data_in;

   logic                       b_write;
   logic signed [SAMPLE_W-1:0] store_val;
   logic [SAMPLE_W-1:0]        ram_rd_data;

   // the word leaving B writes the store at the edge the next one is read
   assign b_write = b_valid_ff && c_free && enable_ff;

   always_comb begin
      b_left_in     = b_left_ff;
      b_right_in    = b_right_ff;
      b_wp_in       = b_wp_ff;
      b_ok_in       = b_ok_ff;
      b_fwd_in      = b_fwd_ff;
      b_fwd_data_in = b_fwd_data_ff;
      if (req_accept) begin
         b_left_in     = req_left_in;
         b_right_in    = req_right_in;
         b_wp_in       = wp_ff;
         b_ok_in       = rd_written;
         // RAM returns old data on a same-address read and write: bypass
         b_fwd_in      = b_write && (b_wp_ff == rd_addr);
         b_fwd_data_in = store_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_fwd_ff <= 1'b0;
      end else begin
         b_fwd_ff <= b_fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      b_left_ff     <= b_left_in;
      b_right_ff    <= b_right_in;
      b_wp_ff       <= b_wp_in;
      b_ok_ff       <= b_ok_in;
      b_fwd_data_ff <= b_fwd_data_in;
   end

   fde_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (b_write),
      .wr_addr (b_wp_ff),
      .wr_data (store_val),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------- stage B: feedback and mix
   logic signed [SAMPLE_W-1:0] dly;
   logic signed [SAMPLE_W:0]   mono_sum;
   logic signed [GAIN_W:0]     gain_s;
   logic signed [32:0]         fb_prod, fb_sum, fb_adj;
   logic signed [17:0]         fb_q;
   logic [LEVEL_W-1:0]         wet_eff;
   logic signed [LEVEL_W:0]    wet_s, dry_s;
   logic signed [24:0]         mix_l, mix_r;

   always_comb begin
      if (b_fwd_ff) begin
         dly = b_fwd_data_ff;
      end else if (b_ok_ff) begin
         dly = $signed(ram_rd_data);
      end else begin
         dly = '0;
      end
   end

   assign mono_sum = SAMPLE_W'(0) + b_left_ff + b_right_ff;
   assign gain_s   = $signed({1'b0, feedback_gain_ff});
   assign fb_prod  = dly * gain_s;
   assign fb_sum   = fb_prod + $signed({{2{mono_sum[SAMPLE_W]}}, mono_sum, 14'b0});
   // divide by 32768 toward zero
   assign fb_adj   = fb_sum + (fb_sum[32] ? 33'sd32767 : 33'sd0);
   assign fb_q     = fb_adj[32:15];

   always_comb begin
      if (fb_q > 18'(FULL_SCALE)) begin
         store_val = FULL_SCALE;
      end else if (fb_q < -18'(FULL_SCALE)) begin
         store_val = -FULL_SCALE;
      end else begin
         store_val = fb_q[SAMPLE_W-1:0];
      end
   end

   // disabled words mix with zero wet share: in*255/255 is exact
   assign wet_eff = enable_ff ? wet_level_ff : '0;
   assign wet_s   = $signed({1'b0, wet_eff});
   assign dry_s   = $signed({1'b0, LEVEL_MAX - wet_eff});
   assign mix_l   = b_left_ff  * dry_s + dly * wet_s;
   assign mix_r   = b_right_ff * dry_s + dly * wet_s;

   // ------------------------------------------------------------ stage C
   logic signed [24:0] c_mix_l_ff, c_mix_l_in;
   logic signed [24:0] c_mix_r_ff, c_mix_r_in;

   assign c_mix_l_in = (c_free && b_valid_ff) ? mix_l : c_mix_l_ff;
   assign c_mix_r_in = (c_free && b_valid_ff) ? mix_r : c_mix_r_ff;

   always_ff @(posedge clock) begin
      c_mix_l_ff <= c_mix_l_in;
      c_mix_r_ff <= c_mix_r_in;
   end

   // m/255, halves away from zero, saturated at full scale on the positive side
   function automatic logic signed [SAMPLE_W-1:0] div255_sat(input logic signed [24:0] m);
      logic [24:0] mag;
      logic [47:0] prod;
      logic [16:0] q;
      logic signed [SAMPLE_W-1:0] res;
      mag  = m[24] ? (25'(127) - m) : (m + 25'(127));
      prod = mag[23:0] * DIV255_RECIP;
      q    = prod[47:DIV255_SHIFT];
      if (m[24]) begin
         res = SAMPLE_W'(17'(0) - q);
      end else if (q > 17'(FULL_SCALE)) begin
         res = FULL_SCALE;
      end else begin
         res = q[SAMPLE_W-1:0];
      end
      return res;
   endfunction

   // ------------------------------------------------------- output register
   logic signed [SAMPLE_W-1:0] o_left_ff,  o_left_in;
   logic signed [SAMPLE_W-1:0] o_right_ff, o_right_in;

   assign o_left_in  = (o_free && c_valid_ff) ? div255_sat(c_mix_l_ff) : o_left_ff;
   assign o_right_in = (o_free && c_valid_ff) ? div255_sat(c_mix_r_ff) : o_right_ff;

   always_ff @(posedge clock) begin
      o_left_ff  <= o_left_in;
      o_right_ff <= o_right_in;
   end

   assign rsp_valid     = o_valid_ff;
   assign rsp_left_out  = o_left_ff;
   assign rsp_right_out = o_right_ff;

endmodule

`default_nettype wire

[rtl/fde_checker.sv]
// fde_checker: port-level checks of feedback_delay_echo, bound to the top level.
// Depends on fde_pkg and feedback_delay_echo_macros.svh.
`default_nettype none
`include "feedback_delay_echo_macros.svh"

module fde_checker
   import fde_pkg::*;
(
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_stall,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_stall,
   input wire logic signed [SAMPLE_W-1:0] rsp_left_out,
   input wire logic signed [SAMPLE_W-1:0] rsp_right_out
);

   // a stalled result word stays
   `FDE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp word dropped while stalled")

   `FDE_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_left_out) && $stable(rsp_right_out), "rsp word changed while stalled")

   // only backpressure from the result side may stall the input
   `FDE_ASSERT_SAME(a_stall_source, clock, reset, req_valid && req_stall, rsp_valid && rsp_stall, "req stalled without rsp backpressure")

   // reset empties the pipeline
   `FDE_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "rsp valid right after reset")

endmodule

bind feedback_delay_echo fde_checker u_fde_checker (.*);

`default_nettype wire
